// ----- rtl/core/particle_wind_velocity_update_macros.svh -----
// ----------------------------------------------------------------------------
// particle wind velocity update: assertion macros
// shared helpers for concurrent checks, clocked on clk, off during reset
// ----------------------------------------------------------------------------
`ifndef PARTICLE_WIND_VELOCITY_UPDATE_MACROS_SVH
`define PARTICLE_WIND_VELOCITY_UPDATE_MACROS_SVH

// property must hold at every edge out of reset
`define PWU_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// expression must never be true out of reset
`define PWU_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`endif

// ----- rtl/core/pwu_pkg.sv -----
// ----------------------------------------------------------------------------
// pwu_pkg
// shared types, constants and arithmetic helpers of the wind velocity update
// ----------------------------------------------------------------------------
package pwu_pkg;

	localparam int FRAC_BITS     = 16;
	localparam int DATA_W        = 32;
	localparam int CFG_AW        = 3;
	localparam int FO_W          = FRAC_BITS + 1;
	localparam int UNIT_W        = FRAC_BITS + 2;
	localparam int RT_STEPS      = DATA_W;
	localparam int DIV_STEPS     = FRAC_BITS;
	localparam int DIR_DIV_STEPS = DATA_W + FRAC_BITS;
	localparam int QUEUE_DEPTH   = 4;
	localparam int QPTR_W        = 2;

	localparam logic [FO_W-1:0] ONE_FX = {1'b1, {FRAC_BITS{1'b0}}};

	typedef enum logic [CFG_AW-1:0] {
		REG_DIR_X,
		REG_DIR_Y,
		REG_DIR_Z,
		REG_STRENGTH,
		REG_TURB,
		REG_RADIUS
	} pwu_reg_t;

	typedef enum logic [2:0] {
		SEQ_IDLE,
		SEQ_SQ,
		SEQ_RT,
		SEQ_DV,
		SEQ_ML,
		SEQ_TB
	} pwu_seq_t;

	// one particle as it waits in the queue
	typedef struct packed {
		logic [2:0][DATA_W-1:0] vel;
		logic [2:0][DATA_W-1:0] pos_abs;
		logic [DATA_W-1:0]      im;
		logic [DATA_W-2:0]      dt;
		logic                   movable;
	} pwu_item_t;

	// what travels down the back pipeline
	typedef struct packed {
		logic [2:0][DATA_W-1:0] vel;
		logic [DATA_W-1:0]      im;
		logic [DATA_W-2:0]      dt;
		logic                   movable;
	} pwu_bk_t;

	// wind settings seen by the back pipeline
	typedef struct packed {
		logic [2:0][DATA_W-1:0] wforce;
		logic [DATA_W-2:0]      radius;
	} pwu_wind_t;

	typedef struct packed {
		logic [DATA_W+1:0] rem;
		logic [DATA_W-1:0] root;
	} pwu_rt_t;

	function automatic logic [DATA_W-1:0] sat32(input logic signed [63:0] v);
		logic [DATA_W-1:0] r;
		if (v > 64'sd2147483647) begin
			r = {1'b0, {(DATA_W-1){1'b1}}};
		end else if (v < -64'sd2147483648) begin
			r = {1'b1, {(DATA_W-1){1'b0}}};
		end else begin
			r = v[DATA_W-1:0];
		end
		return r;
	endfunction

	function automatic logic [DATA_W-1:0] abs32(input logic [DATA_W-1:0] v);
		logic [DATA_W-1:0] r;
		r = v[DATA_W-1] ? (~v + 1'b1) : v;
		return r;
	endfunction

	// one digit of a floor square root, two radicand bits at a time
	function automatic pwu_rt_t rt_step(input pwu_rt_t cur, input logic [1:0] bits);
		pwu_rt_t           nx;
		logic [DATA_W+1:0] rn;
		logic [DATA_W+1:0] trial;
		rn    = {cur.rem[DATA_W-1:0], bits};
		trial = {cur.root, 2'b01};
		if (rn >= trial) begin
			nx.rem  = rn - trial;
			nx.root = {cur.root[DATA_W-2:0], 1'b1};
		end else begin
			nx.rem  = rn;
			nx.root = {cur.root[DATA_W-2:0], 1'b0};
		end
		return nx;
	endfunction

endpackage

// ----- rtl/core/pwu_cfg.sv -----
// ----------------------------------------------------------------------------
// pwu_cfg
// wind registers and the sequencer that turns them into a per-axis force
// ----------------------------------------------------------------------------
`include "particle_wind_velocity_update_macros.svh"

module pwu_cfg (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wr_en,
	input  logic [pwu_pkg::CFG_AW-1:0] cfg_addr,
	input  logic [pwu_pkg::DATA_W-1:0] cfg_wdata,
	output pwu_pkg::pwu_wind_t         wind,
	output logic                       busy
);
	import pwu_pkg::*;

	localparam int CNT_W = $clog2(DIR_DIV_STEPS);

	logic [2:0][DATA_W-1:0] dir_q;
	logic [DATA_W-1:0]      strength_q;
	logic [DATA_W-1:0]      turb_q;
	logic [DATA_W-2:0]      radius_q;
	logic [2:0][DATA_W-1:0] force_q;

	pwu_seq_t          state_q, state_nx;
	logic [1:0]        ax_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [63:0]       acc_q;
	pwu_rt_t           rt_q;
	logic [DATA_W+FRAC_BITS-1:0] num_q;
	logic [DATA_W-1:0] rem_q;
	logic [FO_W-1:0]   quo_q;

	logic              restart;
	logic              ax_last;
	logic              rt_last;
	logic              dv_last;
	logic [DATA_W-1:0] absd;
	logic [DATA_W-1:0] absd_nx;
	logic [63:0]       sqv;
	logic [DATA_W:0]   tr;
	logic signed [UNIT_W-1:0]        unit;
	logic signed [UNIT_W+DATA_W-1:0] uprod;

	assign restart = cfg_wr_en && (cfg_addr == REG_DIR_X || cfg_addr == REG_DIR_Y ||
		cfg_addr == REG_DIR_Z || cfg_addr == REG_STRENGTH || cfg_addr == REG_TURB);

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			SEQ_IDLE: state_nx = SEQ_IDLE;
			SEQ_SQ:   if (ax_last) state_nx = SEQ_RT;
			SEQ_RT:   if (rt_last) state_nx = SEQ_DV;
			SEQ_DV:   if (dv_last) state_nx = SEQ_ML;
			SEQ_ML:   state_nx = ax_last ? SEQ_TB : SEQ_DV;
			SEQ_TB:   state_nx = SEQ_IDLE;
			default:  state_nx = SEQ_IDLE;
		endcase
		if (restart) state_nx = SEQ_SQ;
	end

	// outputs and step flags
	always_comb begin
		busy    = 1'b1;
		ax_last = (ax_q == 2'd2);
		rt_last = (cnt_q == CNT_W'(RT_STEPS - 1));
		dv_last = (cnt_q == CNT_W'(DIR_DIV_STEPS - 1));
		case (state_q)
			SEQ_IDLE: busy = 1'b0;
			default:  busy = 1'b1;
		endcase
	end

	assign absd    = abs32(dir_q[ax_q]);
	assign absd_nx = abs32(dir_q[ax_q + 2'd1]);
	assign sqv     = 64'(absd) * 64'(absd);
	assign tr      = {rem_q, num_q[DATA_W+FRAC_BITS-1]};
	assign unit    = (rt_q.root == '0) ? '0 :
		(dir_q[ax_q][DATA_W-1] ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q}));
	assign uprod   = unit * $signed(strength_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= SEQ_IDLE;
			ax_q       <= '0;
			cnt_q      <= '0;
			dir_q      <= {DATA_W'(0), DATA_W'(0), DATA_W'(ONE_FX)};
			strength_q <= '0;
			turb_q     <= '0;
			radius_q   <= '0;
			force_q    <= '0;
		end else begin
			state_q <= state_nx;
			cnt_q   <= (state_nx != state_q || restart) ? '0 : cnt_q + 1'b1;
			if (restart) begin
				ax_q <= '0;
			end else if (state_q == SEQ_SQ && !ax_last) begin
				ax_q <= ax_q + 1'b1;
			end else if (state_q == SEQ_SQ || state_q == SEQ_RT) begin
				ax_q <= '0;
			end else if (state_q == SEQ_ML && !ax_last) begin
				ax_q <= ax_q + 1'b1;
			end
			if (state_q == SEQ_ML) begin
				force_q[ax_q] <= sat32(64'(uprod >>> FRAC_BITS));
			end
			if (state_q == SEQ_TB && $signed(turb_q) > 0) begin
				force_q[0] <= sat32(64'($signed(force_q[0])) + 64'($signed(turb_q)));
				force_q[1] <= sat32(64'($signed(force_q[1])) + 64'($signed(turb_q) >>> 1));
				force_q[2] <= sat32(64'($signed(force_q[2])) + 64'($signed(turb_q)));
			end
			if (cfg_wr_en) begin
				case (cfg_addr)
					REG_DIR_X:    dir_q[0]   <= cfg_wdata;
					REG_DIR_Y:    dir_q[1]   <= cfg_wdata;
					REG_DIR_Z:    dir_q[2]   <= cfg_wdata;
					REG_STRENGTH: strength_q <= cfg_wdata;
					REG_TURB:     turb_q     <= cfg_wdata;
					REG_RADIUS:   radius_q   <= cfg_wdata[DATA_W-2:0];
					default:      ;
				endcase
			end
		end
	end

	// work registers of the sequencer
	always_ff @(posedge clk) begin
		if (restart) begin
			acc_q <= '0;
		end else begin
			case (state_q)
				SEQ_SQ: begin
					acc_q <= acc_q + sqv;
					rt_q  <= '0;
				end
				SEQ_RT: begin
					rt_q  <= rt_step(rt_q, acc_q[63:62]);
					acc_q <= {acc_q[61:0], 2'b00};
					if (rt_last) begin
						num_q <= {abs32(dir_q[0]), {FRAC_BITS{1'b0}}};
						rem_q <= '0;
						quo_q <= '0;
					end
				end
				SEQ_DV: begin
					num_q <= {num_q[DATA_W+FRAC_BITS-2:0], 1'b0};
					if (tr >= {1'b0, rt_q.root}) begin
						rem_q <= DATA_W'(tr - {1'b0, rt_q.root});
						quo_q <= {quo_q[FO_W-2:0], 1'b1};
					end else begin
						rem_q <= tr[DATA_W-1:0];
						quo_q <= {quo_q[FO_W-2:0], 1'b0};
					end
				end
				SEQ_ML: begin
					num_q <= {absd_nx, {FRAC_BITS{1'b0}}};
					rem_q <= '0;
					quo_q <= '0;
				end
				default: ;
			endcase
		end
	end

	assign wind.wforce = force_q;
	assign wind.radius = radius_q;

	`PWU_ASSERT(a_tb_to_idle, (state_q == SEQ_TB && !restart) |=> (state_q == SEQ_IDLE),
		"force sequencer did not finish after turbulence step")

endmodule

// ----- rtl/core/pwu_front.sv -----
// ----------------------------------------------------------------------------
// pwu_front
// takes requests, classifies them and holds them in a short queue
// ----------------------------------------------------------------------------
`include "particle_wind_velocity_update_macros.svh"

module pwu_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       busy,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [pwu_pkg::DATA_W-2:0] step_dt,
	input  logic [pwu_pkg::DATA_W-1:0] pos_x,
	input  logic [pwu_pkg::DATA_W-1:0] pos_y,
	input  logic [pwu_pkg::DATA_W-1:0] pos_z,
	input  logic [pwu_pkg::DATA_W-1:0] vel_in_x,
	input  logic [pwu_pkg::DATA_W-1:0] vel_in_y,
	input  logic [pwu_pkg::DATA_W-1:0] vel_in_z,
	input  logic [pwu_pkg::DATA_W-1:0] inverse_mass,
	output pwu_pkg::pwu_item_t         head,
	output logic                       head_valid,
	input  logic                       pop
);
	import pwu_pkg::*;

	pwu_item_t         queue_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   cnt_q;
	logic              push;
	pwu_item_t         item;

	assign in_ready   = (cnt_q != (QPTR_W+1)'(QUEUE_DEPTH)) && !busy;
	assign push       = in_valid && in_ready;
	assign head_valid = (cnt_q != '0);
	assign head       = queue_q[rd_ptr_q];

	always_comb begin
		item.vel     = {vel_in_z, vel_in_y, vel_in_x};
		item.pos_abs = {abs32(pos_z), abs32(pos_y), abs32(pos_x)};
		item.im      = inverse_mass;
		item.dt      = step_dt;
		// immovable when inverse mass is zero or negative
		item.movable = !inverse_mass[DATA_W-1] && (inverse_mass != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			cnt_q <= cnt_q + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) queue_q[wr_ptr_q] <= item;
	end

	`PWU_NEVER(a_pop_empty, pop && !head_valid, "queue popped while empty")
	`PWU_NEVER(a_cnt_range, cnt_q > (QPTR_W+1)'(QUEUE_DEPTH), "queue count out of range")
	`PWU_ASSERT(a_cnt_track, (push && !pop) |=> (cnt_q == $past(cnt_q) + 1'b1),
		"queue count missed a push")

endmodule

// ----- rtl/core/pwu_back.sv -----
// ----------------------------------------------------------------------------
// pwu_back
// distance, falloff and impulse pipeline with the output register
// ----------------------------------------------------------------------------
`include "particle_wind_velocity_update_macros.svh"

module pwu_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  pwu_pkg::pwu_item_t         head,
	input  logic                       head_valid,
	output logic                       pop,
	input  pwu_pkg::pwu_wind_t         wind,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [pwu_pkg::DATA_W-1:0] vel_out_x,
	output logic [pwu_pkg::DATA_W-1:0] vel_out_y,
	output logic [pwu_pkg::DATA_W-1:0] vel_out_z,
	output logic                       force_applied
);
	import pwu_pkg::*;

	localparam int ST_RT0 = 2;
	localparam int ST_CMP = ST_RT0 + RT_STEPS;
	localparam int ST_DV0 = ST_CMP + 1;
	localparam int ST_FO  = ST_DV0 + DIV_STEPS;
	localparam int ST_M1  = ST_FO + 1;
	localparam int ST_M2  = ST_M1 + 1;
	localparam int ST_M3  = ST_M2 + 1;
	localparam int NV     = ST_M3 + 1;

	logic              en;
	logic [NV-1:0]     vld_s;
	pwu_bk_t           pl_s [NV];
	pwu_bk_t           hd_bk;
	pwu_bk_t           cmp_bk;

	logic [2:0][63:0]  sq_s1;
	logic [63:0]       sum_s2;
	pwu_rt_t           rt_s  [RT_STEPS];
	logic [63:0]       rad_s [RT_STEPS];
	logic [DATA_W-1:0] pdist;
	logic              far;
	logic [DATA_W-1:0] drem_s [DIV_STEPS+1];
	logic [FRAC_BITS-1:0] quo_s [DIV_STEPS+1];
	logic [FO_W-1:0]   fo_s;
	logic [2:0][DATA_W-1:0] t1_s, t2_s, t3_s;

	logic signed [DATA_W+FO_W:0]  p1 [3];
	logic signed [63:0]           p2 [3];
	logic signed [63:0]           p3 [3];
	logic signed [DATA_W:0]       vs [3];
	logic [2:0][DATA_W-1:0]       vfin;

	logic              out_valid_q;
	logic [2:0][DATA_W-1:0] vel_out_q;
	logic              applied_q;

	assign en  = !out_valid_q || out_ready;
	assign pop = en && head_valid;

	always_comb begin
		hd_bk.vel     = head.vel;
		hd_bk.im      = head.im;
		hd_bk.dt      = head.dt;
		hd_bk.movable = head.movable;
		pdist         = rt_s[RT_STEPS-1].root;
		far           = (wind.radius != '0) && (pdist >= {1'b0, wind.radius});
		cmp_bk        = pl_s[ST_CMP-1];
		// outside the radius the particle is left alone
		cmp_bk.movable = pl_s[ST_CMP-1].movable && !far;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s       <= '0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			vld_s       <= {vld_s[NV-2:0], head_valid};
			out_valid_q <= vld_s[NV-1];
		end
	end

	// payload shift along the pipe
	always_ff @(posedge clk) begin
		if (en) begin
			pl_s[0] <= hd_bk;
			for (int i = 1; i < NV; i++) begin
				pl_s[i] <= (i == ST_CMP) ? cmp_bk : pl_s[i-1];
			end
			for (int a = 0; a < 3; a++) begin
				sq_s1[a] <= 64'(head.pos_abs[a]) * 64'(head.pos_abs[a]);
			end
			sum_s2 <= sq_s1[0] + sq_s1[1] + sq_s1[2];
		end
	end

	// floor square root, one digit per stage
	for (genvar k = 0; k < RT_STEPS; k++) begin : g_rt
		if (k == 0) begin : g_first
			always_ff @(posedge clk) begin
				if (en) begin
					rt_s[k]  <= rt_step('0, sum_s2[63:62]);
					rad_s[k] <= {sum_s2[61:0], 2'b00};
				end
			end
		end else begin : g_next
			always_ff @(posedge clk) begin
				if (en) begin
					rt_s[k]  <= rt_step(rt_s[k-1], rad_s[k-1][63:62]);
					rad_s[k] <= {rad_s[k-1][61:0], 2'b00};
				end
			end
		end
	end

	// ratio of distance to radius, one quotient bit per stage
	always_ff @(posedge clk) begin
		if (en) begin
			drem_s[0] <= pdist;
			quo_s[0]  <= '0;
		end
	end

	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_dv
		logic [DATA_W:0] tr;
		assign tr = {drem_s[k], 1'b0};
		always_ff @(posedge clk) begin
			if (en) begin
				if (tr >= {2'b00, wind.radius}) begin
					drem_s[k+1] <= DATA_W'(tr - {2'b00, wind.radius});
					quo_s[k+1]  <= {quo_s[k][FRAC_BITS-2:0], 1'b1};
				end else begin
					drem_s[k+1] <= tr[DATA_W-1:0];
					quo_s[k+1]  <= {quo_s[k][FRAC_BITS-2:0], 1'b0};
				end
			end
		end
	end

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			p1[a] = $signed(wind.wforce[a]) * $signed({1'b0, fo_s});
			p2[a] = $signed(t1_s[a]) * $signed(pl_s[ST_M1].im);
			p3[a] = $signed(t2_s[a]) * $signed({1'b0, pl_s[ST_M2].dt});
			vs[a] = $signed({pl_s[ST_M3].vel[a][DATA_W-1], pl_s[ST_M3].vel[a]}) +
				$signed({t3_s[a][DATA_W-1], t3_s[a]});
			if (!pl_s[ST_M3].movable) begin
				vfin[a] = pl_s[ST_M3].vel[a];
			end else if (vs[a][DATA_W] != vs[a][DATA_W-1]) begin
				vfin[a] = {vs[a][DATA_W], {(DATA_W-1){!vs[a][DATA_W]}}};
			end else begin
				vfin[a] = vs[a][DATA_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fo_s <= (wind.radius == '0) ? ONE_FX : ONE_FX - {1'b0, quo_s[DIV_STEPS]};
			for (int a = 0; a < 3; a++) begin
				t1_s[a] <= DATA_W'(p1[a] >>> FRAC_BITS);
				t2_s[a] <= sat32(p2[a] >>> FRAC_BITS);
				t3_s[a] <= sat32(p3[a] >>> FRAC_BITS);
			end
			vel_out_q <= vfin;
			applied_q <= pl_s[ST_M3].movable;
		end
	end

	assign out_valid     = out_valid_q;
	assign vel_out_x     = vel_out_q[0];
	assign vel_out_y     = vel_out_q[1];
	assign vel_out_z     = vel_out_q[2];
	assign force_applied = applied_q;

	`PWU_ASSERT(a_stall_hold, !en |=> ($stable(vld_s) && out_valid_q),
		"pipeline moved while output stalled")

endmodule

// ----- rtl/core/particle_wind_velocity_update.sv -----
// ----------------------------------------------------------------------------
// particle_wind_velocity_update
// one wind impulse on one particle velocity, signed Q16.16, saturating
// ----------------------------------------------------------------------------
// usage
//   request channel in_valid/in_ready carries step_dt, position, velocity and
//   inverse mass; result channel out_valid/out_ready carries vel_out_x/y/z and
//   force_applied (low when the particle is immovable or outside the radius)
//   config: cfg_wr_en writes cfg_wdata into register cfg_addr;
//   0..2 wind direction, 3 strength, 4 turbulence, 5 falloff radius;
//   other indexes are ignored
//   a write to registers 0..4 starts the force sequencer: three squares,
//   32 root digits, then per axis a 48-step divide and one multiply, and one
//   turbulence step; in_ready stays low meanwhile
//   throughput: one request per cycle when not busy or stalled, set by the
//   fully pipelined back end (root and divide stages are one digit each)
//   datapath: an accepted request passes the queue, then the 55 back
//   stages behind it, then the output register that drives out_valid
//   reset: registers return to direction (1,0,0), all else zero; queue and
//   pipeline are emptied, no clearing pass needed
//   stall: when out_valid is high and out_ready is low the back pipe freezes
//   and the four-entry queue keeps taking requests until it is full
// ----------------------------------------------------------------------------
module particle_wind_velocity_update (
	input  logic                       clk,
	input  logic                       arst_n,
	// configuration
	input  logic                       cfg_wr_en,
	input  logic [pwu_pkg::CFG_AW-1:0] cfg_addr,
	input  logic [pwu_pkg::DATA_W-1:0] cfg_wdata,
	// request channel
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [pwu_pkg::DATA_W-2:0] step_dt,
	input  logic [pwu_pkg::DATA_W-1:0] pos_x,
	input  logic [pwu_pkg::DATA_W-1:0] pos_y,
	input  logic [pwu_pkg::DATA_W-1:0] pos_z,
	input  logic [pwu_pkg::DATA_W-1:0] vel_in_x,
	input  logic [pwu_pkg::DATA_W-1:0] vel_in_y,
	input  logic [pwu_pkg::DATA_W-1:0] vel_in_z,
	input  logic [pwu_pkg::DATA_W-1:0] inverse_mass,
	// result channel
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [pwu_pkg::DATA_W-1:0] vel_out_x,
	output logic [pwu_pkg::DATA_W-1:0] vel_out_y,
	output logic [pwu_pkg::DATA_W-1:0] vel_out_z,
	output logic                       force_applied
);
	import pwu_pkg::*;

	// wind force per axis, already scaled and with turbulence folded in
	pwu_wind_t wind;
	logic      busy;
	// queue head between front and back
	pwu_item_t head;
	logic      head_valid;
	logic      pop;

	pwu_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.wind      (wind),
		.busy      (busy)
	);

	// front: accept, mark immovable particles, fold positions to magnitudes
	pwu_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.busy         (busy),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.step_dt      (step_dt),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.pos_z        (pos_z),
		.vel_in_x     (vel_in_x),
		.vel_in_y     (vel_in_y),
		.vel_in_z     (vel_in_z),
		.inverse_mass (inverse_mass),
		.head         (head),
		.head_valid   (head_valid),
		.pop          (pop)
	);

	// back: distance, falloff, mass and dt scaling, saturating add
	pwu_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (head),
		.head_valid    (head_valid),
		.pop           (pop),
		.wind          (wind),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.vel_out_x     (vel_out_x),
		.vel_out_y     (vel_out_y),
		.vel_out_z     (vel_out_z),
		.force_applied (force_applied)
	);

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// checks the wind velocity update block against its own prediction of every
// particle, under random idle gaps on both channels and several wind settings
// ----------------------------------------------------------------------------
module tb;
	import pwu_pkg::*;

	localparam int CYCLE_LIMIT = 600000;
	localparam int DRAIN_WAIT = 80;   // longer than the request latency
	localparam logic [CFG_AW-1:0] CFG_UNUSED_IDX = 3'd6;
	localparam logic [31:0] Q_ONE = 32'h0001_0000;
	localparam logic [31:0] S_MAX = 32'h7fff_ffff;
	localparam logic [31:0] S_MIN = 32'h8000_0000;

	typedef struct {
		logic [30:0] dt;
		logic [31:0] pos[3];
		logic [31:0] vel[3];
		logic [31:0] im;
	} particle_t;

	typedef struct {
		logic [31:0] vel[3];
		logic        applied;
	} vel_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [CFG_AW-1:0] cfg_addr = '0;
	logic [31:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [30:0] step_dt = '0;
	logic [31:0] pos_x = '0, pos_y = '0, pos_z = '0;
	logic [31:0] vel_in_x = '0, vel_in_y = '0, vel_in_z = '0;
	logic [31:0] inverse_mass = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [31:0] vel_out_x, vel_out_y, vel_out_z;
	logic force_applied;

	particle_t   particles_pending[$];
	vel_result_t vel_expected[$];
	logic [31:0] wind_cfg[6];   // shadow of the wind registers

	int fail_cnt = 0;
	int results_seen = 0;
	int applied_seen = 0;
	int cycle_cnt = 0;
	int cfg_sets = 0;

	particle_wind_velocity_update dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// prediction
	// ------------------------------------------------------------------------
	function automatic longint clamp32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	// floor root of the sum of squares, digit by digit
	function automatic longint unsigned vec_len(longint a, longint b, longint c);
		longint unsigned s, r, bit_w;
		s = longint'(a * a) + longint'(b * b) + longint'(c * c);
		r = 0;
		bit_w = 64'd1 << 62;
		while (bit_w > s) bit_w >>= 2;
		while (bit_w != 0) begin
			if (s >= r + bit_w) begin
				s -= r + bit_w;
				r = (r >> 1) + bit_w;
			end else begin
				r >>= 1;
			end
			bit_w >>= 2;
		end
		return r;
	endfunction

	function automatic vel_result_t wind_velocity(particle_t p);
		vel_result_t r;
		longint im, dt, fo, strength, turb, unit, t;
		longint ps[3], vs[3], f[3], dr[3];
		longint unsigned radial, ratio, dmag;
		bit applied;
		im = longint'($signed(p.im));
		dt = longint'(p.dt);
		fo = 64'sd65536;
		strength = longint'($signed(wind_cfg[REG_STRENGTH]));
		turb = longint'($signed(wind_cfg[REG_TURB]));
		applied = 1'b0;
		for (int i = 0; i < 3; i++) begin
			ps[i] = longint'($signed(p.pos[i]));
			vs[i] = longint'($signed(p.vel[i]));
		end
		// immovable particles and particles beyond the radius pass through
		if (im > 0) begin
			applied = 1'b1;
			if (wind_cfg[REG_RADIUS][30:0] != 0) begin
				radial = vec_len(ps[0], ps[1], ps[2]);
				ratio = (radial << FRAC_BITS) / longint'(wind_cfg[REG_RADIUS][30:0]);
				if (ratio > 64'd65536) ratio = 64'd65536;
				fo = 64'sd65536 - longint'(ratio);
				if (fo <= 0) applied = 1'b0;
			end
		end
		if (applied) begin
			for (int i = 0; i < 3; i++)
				dr[i] = longint'($signed(wind_cfg[REG_DIR_X + i]));
			dmag = vec_len(dr[0], dr[1], dr[2]);
			for (int i = 0; i < 3; i++) begin
				// zero direction leaves only turbulence
				unit = 0;
				if (dmag != 0) unit = (dr[i] * 64'sd65536) / longint'(dmag);
				f[i] = clamp32((unit * strength) >>> FRAC_BITS);
			end
			if (turb > 0) begin
				f[0] = clamp32(f[0] + turb);
				f[1] = clamp32(f[1] + (turb >>> 1));
				f[2] = clamp32(f[2] + turb);
			end
			for (int i = 0; i < 3; i++) begin
				t = (f[i] * fo) >>> FRAC_BITS;
				t = clamp32((t * im) >>> FRAC_BITS);
				t = clamp32((t * dt) >>> FRAC_BITS);
				vs[i] = clamp32(vs[i] + t);
			end
		end
		for (int i = 0; i < 3; i++) r.vel[i] = vs[i][31:0];
		r.applied = applied;
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// request driver: random gaps, sometimes long, with steady stretches
	// ------------------------------------------------------------------------
	int  send_gap = 0;
	bit  send_steady = 1'b0;

	always @(posedge clk or negedge arst_n) begin
		particle_t nxt;
		particle_t cur;
		int r;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!(in_valid && !in_ready)) begin
			if (in_valid) begin
				// accepted now: predict with the payload still on the pins
				cur.dt = step_dt;
				cur.pos[0] = pos_x;
				cur.pos[1] = pos_y;
				cur.pos[2] = pos_z;
				cur.vel[0] = vel_in_x;
				cur.vel[1] = vel_in_y;
				cur.vel[2] = vel_in_z;
				cur.im = inverse_mass;
				vel_expected.push_back(wind_velocity(cur));
			end
			if ($urandom_range(0, 63) == 0) send_steady = !send_steady;
			if (send_gap > 0) begin
				send_gap--;
				in_valid <= 1'b0;
			end else if (particles_pending.size() > 0) begin
				nxt = particles_pending.pop_front();
				step_dt <= nxt.dt;
				pos_x <= nxt.pos[0];
				pos_y <= nxt.pos[1];
				pos_z <= nxt.pos[2];
				vel_in_x <= nxt.vel[0];
				vel_in_y <= nxt.vel[1];
				vel_in_z <= nxt.vel[2];
				inverse_mass <= nxt.im;
				in_valid <= 1'b1;
				r = $urandom_range(0, 99);
				if (send_steady || r < 60) send_gap = 0;
				else if (r < 92) send_gap = $urandom_range(1, 3);
				else send_gap = $urandom_range(10, 40);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------------
	// result monitor and receiver stalls, one long hold-off to fill the queue
	// ------------------------------------------------------------------------
	int  hold_cnt = 0;
	bit  pressure_done = 1'b0;

	always @(posedge clk or negedge arst_n) begin
		vel_result_t want;
		int r;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				results_seen++;
				if (force_applied) applied_seen++;
				if (vel_expected.size() == 0) begin
					$error("result with nothing expected: vel %h %h %h applied %b",
						vel_out_x, vel_out_y, vel_out_z, force_applied);
					fail_cnt++;
				end else begin
					want = vel_expected.pop_front();
					if (vel_out_x !== want.vel[0]) begin
						$error("vel_out_x expected %h got %h", want.vel[0], vel_out_x);
						fail_cnt++;
					end
					if (vel_out_y !== want.vel[1]) begin
						$error("vel_out_y expected %h got %h", want.vel[1], vel_out_y);
						fail_cnt++;
					end
					if (vel_out_z !== want.vel[2]) begin
						$error("vel_out_z expected %h got %h", want.vel[2], vel_out_z);
						fail_cnt++;
					end
					if (force_applied !== want.applied) begin
						$error("force_applied expected %b got %b", want.applied,
							force_applied);
						fail_cnt++;
					end
				end
			end
			if (!pressure_done && results_seen >= 400) begin
				pressure_done = 1'b1;
				hold_cnt = 300;
			end
			r = $urandom_range(0, 99);
			if (hold_cnt > 0) begin
				hold_cnt--;
				out_ready <= 1'b0;
			end else if (send_steady || r < 70) begin
				out_ready <= 1'b1;
			end else if (r < 97) begin
				out_ready <= 1'b0;
			end else begin
				hold_cnt = $urandom_range(10, 40);
				out_ready <= 1'b0;
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d requests still expected",
				cycle_cnt, vel_expected.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// stimulus
	// ------------------------------------------------------------------------
	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 6))
			0, 1: return $urandom;
			2: return $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
			3: return S_MAX;
			4: return S_MIN;
			5: return '0;
			default: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
		endcase
	endfunction

	function automatic particle_t rand_particle();
		particle_t p;
		logic [31:0] w;
		w = rand_word();
		p.dt = ($urandom_range(0, 3) == 0) ? w[30:0] : 31'($urandom_range(0, 32'h0002_0000));
		for (int i = 0; i < 3; i++) begin
			p.pos[i] = rand_word();
			p.vel[i] = rand_word();
		end
		case ($urandom_range(0, 5))
			0: p.im = rand_word();
			1: p.im = -$urandom_range(0, 32'h0004_0000);
			default: p.im = $urandom_range(1, 32'h0004_0000);
		endcase
		return p;
	endfunction

	function automatic particle_t mk(logic [30:0] dt, logic [31:0] px, logic [31:0] py,
			logic [31:0] pz, logic [31:0] vx, logic [31:0] vy, logic [31:0] vz,
			logic [31:0] im);
		particle_t p;
		p.dt = dt;
		p.pos[0] = px;
		p.pos[1] = py;
		p.pos[2] = pz;
		p.vel[0] = vx;
		p.vel[1] = vy;
		p.vel[2] = vz;
		p.im = im;
		return p;
	endfunction

	// quiet until every request has come back, then let the pipe settle
	task automatic wait_idle();
		while (particles_pending.size() > 0 || in_valid || vel_expected.size() > 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_AW-1:0] idx, logic [31:0] val);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		if (idx <= REG_RADIUS) wind_cfg[idx] = (idx == REG_RADIUS) ? {1'b0, val[30:0]} : val;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic set_wind(logic [31:0] dx, logic [31:0] dy, logic [31:0] dz,
			logic [31:0] st, logic [31:0] tu, logic [31:0] rad);
		wait_idle();
		write_reg(REG_DIR_X, dx);
		write_reg(REG_DIR_Y, dy);
		write_reg(REG_DIR_Z, dz);
		write_reg(REG_STRENGTH, st);
		write_reg(REG_TURB, tu);
		write_reg(REG_RADIUS, rad);
		cfg_sets++;
	endtask

	initial begin
		logic [31:0] rad;
		wind_cfg[REG_DIR_X] = Q_ONE;
		for (int i = 1; i < 6; i++) wind_cfg[i] = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: zero strength, velocity passes; force applied only when movable
		particles_pending.push_back(mk(31'h10000, 0, 0, 0, 32'h12345, 5, S_MIN, Q_ONE));
		particles_pending.push_back(mk(31'h10000, 0, 0, 0, 1, 2, 3, 0));

		// plain wind with turbulence, no falloff
		set_wind(32'h0003_0000, 32'h0004_0000, 0, 32'h0002_0000, 32'h0000_8000, 0);
		particles_pending.push_back(mk(31'h10000, 0, 0, 0, 0, 0, 0, Q_ONE));
		particles_pending.push_back(mk(31'h10000, 0, 0, 0, 5, 6, 7, S_MIN));
		particles_pending.push_back(mk(31'h10000, 0, 0, 0, 5, 6, 7, 32'hffff_ffff));
		particles_pending.push_back(mk(0, 0, 0, 0, 5, 6, 7, Q_ONE));
		particles_pending.push_back(mk(31'h7fff_ffff, 0, 0, 0, S_MAX, S_MIN, 0, S_MAX));
		particles_pending.push_back(mk(31'h7fff_ffff, 0, 0, 0, S_MIN, S_MAX, S_MAX, 1));
		particles_pending.push_back(mk(1, S_MAX, S_MIN, 0, 0, 0, 0, 1));
		// unused index must change nothing
		wait_idle();
		write_reg(CFG_UNUSED_IDX, 32'hdead_beef);
		particles_pending.push_back(mk(31'h10000, 0, 0, 0, 0, 0, 0, Q_ONE));

		// falloff radius of 100: at origin, inside, on the edge, far outside, immovable
		set_wind(S_MIN, 0, 32'h0000_0001, S_MAX, 0, 32'h0064_0000);
		particles_pending.push_back(mk(31'h10000, 0, 0, 0, 0, 0, 0, Q_ONE));
		particles_pending.push_back(mk(31'h10000, 32'h0032_0000, 0, 0, 0, 0, 0, Q_ONE));
		particles_pending.push_back(mk(31'h10000, 0, 32'h0064_0000, 0, 9, 9, 9, Q_ONE));
		particles_pending.push_back(mk(31'h10000, S_MIN, S_MIN, S_MIN, 9, 9, 9, Q_ONE));
		particles_pending.push_back(mk(31'h10000, 0, 0, 32'hffc0_0000, 0, 0, 0, 0));

		// zero direction, only turbulence at its largest
		set_wind(0, 0, 0, S_MAX, S_MAX, 0);
		particles_pending.push_back(mk(31'h10000, 0, 0, 0, 0, 0, 0, Q_ONE));
		particles_pending.push_back(mk(31'h7fff_ffff, 0, 0, 0, S_MAX, 0, S_MIN, S_MAX));

		// extreme direction and strength, negative turbulence, widest and narrowest radius
		set_wind(S_MAX, S_MAX, S_MAX, S_MIN, S_MIN, 32'h7fff_ffff);
		particles_pending.push_back(mk(31'h7fff_ffff, 0, 0, 0, 0, 0, 0, S_MAX));
		particles_pending.push_back(mk(31'h10000, S_MAX, S_MAX, S_MAX, 0, 0, 0, Q_ONE));
		set_wind(S_MIN, S_MIN, S_MIN, S_MAX, 32'h0001_0000, 32'h0000_0001);
		particles_pending.push_back(mk(31'h10000, 0, 0, 0, 0, 0, 0, Q_ONE));
		particles_pending.push_back(mk(31'h10000, 1, 0, 0, 0, 0, 0, Q_ONE));

		// random wind settings, each followed by a batch of particles
		for (int ph = 0; ph < 8; ph++) begin
			case ($urandom_range(0, 3))
				0: rad = '0;
				1: rad = $urandom_range(1, 32'h0100_0000);
				2: begin
					rad = rand_word();
					rad[31] = 1'b0;
				end
				default: rad = $urandom_range(32'h0010_0000, 32'h7fff_ffff);
			endcase
			set_wind(rand_word(), rand_word(), rand_word(), rand_word(), rand_word(), rad);
			for (int k = 0; k < 205; k++) particles_pending.push_back(rand_particle());
		end

		wait_idle();
		$display("%0d particles checked under %0d wind settings, %0d of them pushed by wind",
			results_seen, cfg_sets, applied_seen);
		if (fail_cnt == 0 && vel_expected.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
